// ===== rtl/ssd_pkg.sv =====
// ssd_pkg: shared types and constants for the seven-segment decimal display unit.
// Used by every module under rtl/; depends on nothing.
package ssd_pkg;

    localparam int MAG_W       = 17;      // magnitude of a 16-bit signed value, 32768 included
    localparam int PLACE_W     = 5;       // 1-based place numbers and place sums
    localparam int RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;  // ceil(2^19 / 10)
    localparam int RECIP_SHIFT = 19;      // exact quotient for values below 43699
    localparam logic [7:0] SEG_DOT   = 8'h80;
    localparam logic [7:0] SEG_MINUS = 8'h40;

    typedef struct packed {
        logic               neg;
        logic [MAG_W-1:0]   mag;
        logic [3:0]         first;
        logic [3:0]         count;
        logic [3:0]         point;
        logic               run_digits;
        logic               dot_en;
    } ssd_item_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIGITS,
        BS_EMIT
    } ssd_bstate_t;

    function automatic logic [7:0] digit_shape(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/ssd_front.sv =====
// ssd_front: classifies an input word into a display job (sign, magnitude, range checks).
// Depends on ssd_pkg.
module ssd_front #(
    parameter int PLACES = 8
) (
    input  logic signed [15:0]  value,
    input  logic [3:0]          first_place,
    input  logic [3:0]          digit_count,
    input  logic [3:0]          point_place,
    output ssd_pkg::ssd_item_t  item
);

    localparam logic [ssd_pkg::PLACE_W-1:0] PLACES_P = ssd_pkg::PLACE_W'(PLACES);

    always_comb
    begin
        item.neg   = value[15];
        // two's complement negate in 17 bits keeps -32768 as 32768
        item.mag   = value[15] ? (ssd_pkg::MAG_W'({1'b0, ~value}) + ssd_pkg::MAG_W'(1))
                               : ssd_pkg::MAG_W'({1'b0, value});
        item.first = first_place;
        item.count = digit_count;
        item.point = point_place;
        item.run_digits = (first_place != 4'd0) && ({1'b0, first_place} <= PLACES_P)
                          && (digit_count != 4'd0);
        item.dot_en = (point_place != 4'd0) && ({1'b0, point_place} <= PLACES_P);
    end

endmodule

// ===== rtl/ssd_queue.sv =====
// ssd_queue: two-entry job queue between front and back.
// Depends on ssd_pkg.
module ssd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  ssd_pkg::ssd_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output ssd_pkg::ssd_item_t  pop_item
);

    ssd_pkg::ssd_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("queue count not decremented on pop");

endmodule

// ===== rtl/ssd_back.sv =====
// ssd_back: writes digits into the place buffer, then sweeps the buffer out as a frame,
// merging dot and minus on the way. Depends on ssd_pkg.
module ssd_back #(
    parameter int PLACES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  ssd_pkg::ssd_item_t  job,
    output logic                frame_valid,
    input  logic                frame_ready,
    output logic [7:0]          segment_byte,
    output logic                last
);

    localparam int IW = (PLACES > 1) ? $clog2(PLACES) : 1;
    localparam int PW = ssd_pkg::PLACE_W;
    localparam int MW = ssd_pkg::MAG_W;
    localparam logic [PW-1:0] PLACES_P = PW'(PLACES);
    localparam logic [IW-1:0] K_LAST   = IW'(PLACES - 1);

    ssd_pkg::ssd_bstate_t state_reg, state_next;
    ssd_pkg::ssd_item_t   item_reg;
    logic [PW-1:0]        place_reg;
    logic [3:0]           iter_reg;
    logic [MW-1:0]        mag_reg;
    logic [PW-1:0]        shown_reg;
    logic [IW-1:0]        k_reg;
    logic [7:0]           store_reg [PLACES];
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic [MW+ssd_pkg::RECIP_W-1:0] prod;
    logic [MW-1:0]        quo, quo10;
    logic [3:0]           rem;
    logic                 keep;
    logic                 dig_done;
    logic                 emit_fire;
    logic                 emit_last;
    logic [PW-1:0]        minus_idx;
    logic [7:0]           emit_byte;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    logic [7:0]           wr_data;

    // outputs and datapath
    always_comb
    begin
        job_ready = (state_reg == ssd_pkg::BS_IDLE);
        prod      = mag_reg * ssd_pkg::RECIP_TEN;
        quo       = MW'(prod >> ssd_pkg::RECIP_SHIFT);
        quo10     = (quo << 3) + (quo << 1);
        // remainder is below ten, so the low four bits of the difference are exact
        rem       = 4'(mag_reg - quo10);
        keep      = (iter_reg == 4'd0) || (mag_reg != '0) || (place_reg <= {1'b0, item_reg.point});
        dig_done  = (iter_reg == item_reg.count - 4'd1) || (place_reg >= PLACES_P);
        emit_fire = (!out_valid_reg || frame_ready);
        emit_last = (k_reg == K_LAST);
        minus_idx = PW'({1'b0, item_reg.first}) - PW'(1) + shown_reg;

        emit_byte = store_reg[k_reg];
        if (item_reg.dot_en && (PW'(k_reg) == PW'({1'b0, item_reg.point}) - PW'(1)))
        begin
            emit_byte = emit_byte | ssd_pkg::SEG_DOT;
        end
        // minus replaces the whole place, dot included
        if (item_reg.neg && (item_reg.first != 4'd0) && (minus_idx < PLACES_P)
            && (PW'(k_reg) == minus_idx))
        begin
            emit_byte = ssd_pkg::SEG_MINUS;
        end

        wr_en   = 1'b0;
        wr_idx  = k_reg;
        wr_data = emit_byte;
        unique case (state_reg)
            ssd_pkg::BS_IDLE:
            begin
                wr_en = 1'b0;
            end
            ssd_pkg::BS_DIGITS:
            begin
                wr_en   = 1'b1;
                wr_idx  = IW'(place_reg - PW'(1));
                wr_data = keep ? ssd_pkg::digit_shape(rem) : 8'h00;
            end
            ssd_pkg::BS_EMIT:
            begin
                wr_en = emit_fire;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssd_pkg::BS_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.run_digits ? ssd_pkg::BS_DIGITS : ssd_pkg::BS_EMIT;
                end
            end
            ssd_pkg::BS_DIGITS:
            begin
                if (dig_done)
                begin
                    state_next = ssd_pkg::BS_EMIT;
                end
            end
            ssd_pkg::BS_EMIT:
            begin
                if (emit_fire && emit_last)
                begin
                    state_next = ssd_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = ssd_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssd_pkg::BS_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            place_reg     <= '0;
            iter_reg      <= '0;
            shown_reg     <= '0;
            for (int j = 0; j < PLACES; j++)
            begin
                store_reg[j] <= 8'h00;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                store_reg[wr_idx] <= wr_data;
            end
            if (state_reg == ssd_pkg::BS_IDLE && job_valid)
            begin
                place_reg <= PW'({1'b0, job.first});
                iter_reg  <= 4'd0;
                shown_reg <= '0;
                k_reg     <= '0;
            end
            else if (state_reg == ssd_pkg::BS_DIGITS)
            begin
                place_reg <= place_reg + PW'(1);
                iter_reg  <= iter_reg + 4'd1;
                if (keep)
                begin
                    shown_reg <= shown_reg + PW'(1);
                end
            end
            if (state_reg == ssd_pkg::BS_EMIT && emit_fire)
            begin
                out_valid_reg <= 1'b1;
                k_reg         <= emit_last ? '0 : k_reg + 1'b1;
            end
            else if (frame_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ssd_pkg::BS_IDLE && job_valid)
        begin
            item_reg <= job;
            mag_reg  <= job.mag;
        end
        else if (state_reg == ssd_pkg::BS_DIGITS)
        begin
            mag_reg <= quo;
        end
        if (state_reg == ssd_pkg::BS_EMIT && emit_fire)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign frame_valid  = out_valid_reg;
    assign segment_byte = out_byte_reg;
    assign last         = out_last_reg;

    a_place_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssd_pkg::BS_DIGITS) |-> (place_reg != '0 && place_reg <= PLACES_P))
        else $error("digit place outside buffer");
    a_shown_bound: assert property (@(posedge clk) disable iff (!rst_n)
        shown_reg <= PLACES_P)
        else $error("more digits shown than places");
    a_last_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (state_reg != ssd_pkg::BS_EMIT || k_reg == '0))
        else $error("frame end out of step with sweep");
    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssd_pkg::BS_EMIT && emit_fire && !emit_last)
        |=> (k_reg == $past(k_reg) + 1'b1))
        else $error("sweep skipped a place");

endmodule

// ===== rtl/seven_segment_signed_decimal_display_unit.sv =====
// Seven-segment signed decimal display unit: top level, front -> queue -> back.
// Throughput: one frame of PLACES bytes per word, set by the byte-per-cycle buffer sweep
// (while frame_ready does not stall it) and the one-digit-per-cycle divide by ten; the back
// takes the next word only once the sweep of the last one is done.
// Reset: buffer cleared to blank, queue empty, no bytes emitted. Depends on ssd_pkg.
module seven_segment_signed_decimal_display_unit #(
    parameter int PLACES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic signed [15:0] value,
    input  logic [3:0]         first_place,
    input  logic [3:0]         digit_count,
    input  logic [3:0]         point_place,
    output logic               frame_valid,
    input  logic               frame_ready,
    output logic [7:0]         segment_byte,
    output logic               last
);

    ssd_pkg::ssd_item_t front_item;
    ssd_pkg::ssd_item_t queued_item;
    logic               job_valid;
    logic               job_ready;

    ssd_front #(
        .PLACES (PLACES)
    ) u_front (
        .value       (value),
        .first_place (first_place),
        .digit_count (digit_count),
        .point_place (point_place),
        .item        (front_item)
    );

    ssd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_valid),
        .push_ready (item_ready),
        .push_item  (front_item),
        .pop_valid  (job_valid),
        .pop_ready  (job_ready),
        .pop_item   (queued_item)
    );

    ssd_back #(
        .PLACES (PLACES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (queued_item),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .segment_byte (segment_byte),
        .last         (last)
    );

endmodule
